/* hdl/bba_pkg.sv */
// types, constants and helpers shared by the buddy block allocator
// no dependencies
package bba_pkg;

  localparam int LEVELS      = 10;
  localparam int TOTAL_UNITS = 1 << LEVELS;
  localparam int NODE_COUNT  = (2 << LEVELS) - 1;
  localparam int IDX_W       = LEVELS + 1;
  localparam int LVL_W       = 4;
  localparam int OFF_W       = 10;
  localparam int SIZE_W      = 11;

  localparam logic [1:0] ST_ABSENT = 2'd0;
  localparam logic [1:0] ST_FREE   = 2'd1;
  localparam logic [1:0] ST_ALLOC  = 2'd2;
  localparam logic [1:0] ST_SPLIT  = 2'd3;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_INVALID  = 2'd1;
  localparam logic [1:0] RES_NO_SPACE = 2'd2;
  localparam logic [1:0] RES_BAD_FREE = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] units_asked;
    logic [OFF_W-1:0]  block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  granted_offset;
    logic [SIZE_W-1:0] granted_size;
    logic [SIZE_W-1:0] allocated_total;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [1:0]       wdata;
  } node_req_t;

  typedef struct packed {
    logic              we;
    logic [OFF_W-1:0]  waddr;
    logic [SIZE_W-1:0] wdata;
    logic [OFF_W-1:0]  raddr;
  } units_req_t;

  function automatic logic [OFF_W-1:0] node_offset(input logic [IDX_W-1:0] idx,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] rel;
    logic [LVL_W-1:0] sh;
    rel = idx + IDX_W'(1) - (IDX_W'(1) << lvl);
    sh  = LVL_W'(LEVELS) - lvl;
    return OFF_W'(rel << sh);
  endfunction

endpackage

/* hdl/bba_node_mem.sv */
// node status memory of the buddy tree, one port, registered read
// depends on bba_pkg
module bba_node_mem (
  input  logic              clk,
  input  bba_pkg::node_req_t req,
  output logic [1:0]        rdata
);
  import bba_pkg::*;

  logic [1:0] mem [NODE_COUNT];
  logic [1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;
endmodule

/* hdl/bba_units_mem.sv */
// requested unit count per block start, registered read
// depends on bba_pkg
module bba_units_mem (
  input  logic                       clk,
  input  bba_pkg::units_req_t        req,
  output logic [bba_pkg::SIZE_W-1:0] rdata
);
  import bba_pkg::*;

  logic [SIZE_W-1:0] mem [TOTAL_UNITS];
  logic [SIZE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hdl/buddy_block_allocator_top.sv */
// Binary buddy allocator over 1024 units. After reset the node memory is
// cleared one node a cycle, all 2047 nodes, before the first transaction is
// taken. One transaction at a time: an allocate rounds the size up to a power
// of two by doubling, at most ten times, then walks the tree depth first with
// one node read or write per cycle, splitting free nodes on the way down. A
// free walks down the tree to the allocated block, then merges it upward with
// its buddy level by level while the buddy is free. The node memory has a single port.
// The result sits in an output register, and the next transaction is taken
// once it is loaded.
// depends on bba_pkg, bba_node_mem, bba_units_mem
module buddy_block_allocator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::out_item_t out_data
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SIZE  = 4'd2;
  localparam logic [3:0] S_A_RD  = 4'd3;
  localparam logic [3:0] S_A_EV  = 4'd4;
  localparam logic [3:0] S_A_SPR = 4'd5;
  localparam logic [3:0] S_A_SPL = 4'd6;
  localparam logic [3:0] S_A_UP  = 4'd7;
  localparam logic [3:0] S_F_RD  = 4'd8;
  localparam logic [3:0] S_F_EV  = 4'd9;
  localparam logic [3:0] S_F_SUB = 4'd10;
  localparam logic [3:0] S_F_MRD = 4'd11;
  localparam logic [3:0] S_F_MEV = 4'd12;
  localparam logic [3:0] S_F_M2  = 4'd13;
  localparam logic [3:0] S_F_M3  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [OFF_W-1:0]  offs_r, offs_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [LVL_W-1:0]  tgt_r, tgt_nxt;
  logic [SIZE_W-1:0] p_r, p_nxt;
  logic [SIZE_W-1:0] total_r, total_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [OFF_W-1:0]  goff_r, goff_nxt;
  logic [SIZE_W-1:0] gsize_r, gsize_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  node_req_t         node_req;
  units_req_t        units_req;
  logic [1:0]        node_rdata;
  logic [SIZE_W-1:0] units_rdata;

  logic [IDX_W-1:0]  left_idx, right_idx, parent_idx, buddy_idx;
  logic [OFF_W-1:0]  low_mask, dir_sel;
  logic [LVL_W-1:0]  down_sh;

  bba_node_mem u_node_mem (
    .clk   (clk),
    .req   (node_req),
    .rdata (node_rdata)
  );

  bba_units_mem u_units_mem (
    .clk   (clk),
    .req   (units_req),
    .rdata (units_rdata)
  );

  assign left_idx   = {idx_r[IDX_W-2:0], 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;
  assign buddy_idx  = idx_r[0] ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
  assign down_sh    = LVL_W'(LEVELS - 1) - lvl_r;
  assign dir_sel    = offs_r >> down_sh;
  assign low_mask   = OFF_W'((IDX_W'(1) << (LVL_W'(LEVELS) - lvl_r)) - IDX_W'(1));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    offs_nxt      = offs_r;
    idx_nxt       = idx_r;
    lvl_nxt       = lvl_r;
    tgt_nxt       = tgt_r;
    p_nxt         = p_r;
    total_nxt     = total_r;
    status_nxt    = status_r;
    goff_nxt      = goff_r;
    gsize_nxt     = gsize_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    node_req      = '{we: 1'b0, addr: idx_r, wdata: ST_ABSENT};
    units_req     = '{we: 1'b0, waddr: goff_r, wdata: req_r, raddr: offs_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        node_req = '{we: 1'b1, addr: clr_r,
                     wdata: (clr_r == '0) ? ST_FREE : ST_ABSENT};
        clr_nxt  = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data.units_asked;
          offs_nxt   = in_data.block_offset;
          status_nxt = RES_OK;
          goff_nxt   = '0;
          gsize_nxt  = '0;
          idx_nxt    = '0;
          lvl_nxt    = '0;
          p_nxt      = SIZE_W'(1);
          tgt_nxt    = LVL_W'(LEVELS);
          if (in_data.func == FUNC_ALLOC) begin
            if (in_data.units_asked == '0 ||
                in_data.units_asked >= SIZE_W'(TOTAL_UNITS)) begin
              status_nxt = RES_INVALID;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SIZE;
            end
          end else begin
            if ({1'b0, in_data.block_offset} >= SIZE_W'(TOTAL_UNITS)) begin
              status_nxt = RES_BAD_FREE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_F_RD;
            end
          end
        end
      end
      S_SIZE: begin
        if (p_r < req_r) begin
          p_nxt   = p_r << 1;
          tgt_nxt = tgt_r - LVL_W'(1);
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_RD: begin
        state_nxt = S_A_EV;
      end
      S_A_EV: begin
        if (lvl_r == tgt_r) begin
          if (node_rdata == ST_FREE) begin
            node_req  = '{we: 1'b1, addr: idx_r, wdata: ST_ALLOC};
            goff_nxt  = node_offset(idx_r, lvl_r);
            gsize_nxt = p_r;
            units_req.we    = 1'b1;
            units_req.waddr = node_offset(idx_r, lvl_r);
            total_nxt = total_r + req_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_UP;
          end
        end else if (node_rdata == ST_FREE) begin
          node_req  = '{we: 1'b1, addr: idx_r, wdata: ST_SPLIT};
          state_nxt = S_A_SPR;
        end else if (node_rdata == ST_SPLIT) begin
          idx_nxt   = left_idx;
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = S_A_RD;
        end else begin
          state_nxt = S_A_UP;
        end
      end
      S_A_SPR: begin
        node_req  = '{we: 1'b1, addr: right_idx, wdata: ST_FREE};
        state_nxt = S_A_SPL;
      end
      S_A_SPL: begin
        node_req  = '{we: 1'b1, addr: left_idx, wdata: ST_FREE};
        idx_nxt   = left_idx;
        lvl_nxt   = lvl_r + LVL_W'(1);
        state_nxt = S_A_RD;
      end
      S_A_UP: begin
        if (idx_r == '0) begin
          status_nxt = RES_NO_SPACE;
          state_nxt  = S_DONE;
        end else if (!idx_r[0]) begin
          idx_nxt = parent_idx;
          lvl_nxt = lvl_r - LVL_W'(1);
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_A_RD;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_EV;
      end
      S_F_EV: begin
        if (node_rdata == ST_SPLIT && lvl_r < LVL_W'(LEVELS)) begin
          idx_nxt   = dir_sel[0] ? right_idx : left_idx;
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = S_F_RD;
        end else if (node_rdata == ST_ALLOC && (offs_r & low_mask) == '0) begin
          node_req  = '{we: 1'b1, addr: idx_r, wdata: ST_FREE};
          goff_nxt  = offs_r;
          gsize_nxt = SIZE_W'(TOTAL_UNITS) >> lvl_r;
          state_nxt = S_F_SUB;
        end else begin
          status_nxt = RES_BAD_FREE;
          state_nxt  = S_DONE;
        end
      end
      S_F_SUB: begin
        total_nxt = total_r - units_rdata;
        state_nxt = (lvl_r == '0) ? S_DONE : S_F_MRD;
      end
      S_F_MRD: begin
        node_req.addr = buddy_idx;
        state_nxt     = S_F_MEV;
      end
      S_F_MEV: begin
        if (node_rdata == ST_FREE) begin
          node_req  = '{we: 1'b1, addr: idx_r, wdata: ST_ABSENT};
          state_nxt = S_F_M2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F_M2: begin
        node_req  = '{we: 1'b1, addr: buddy_idx, wdata: ST_ABSENT};
        state_nxt = S_F_M3;
      end
      S_F_M3: begin
        node_req  = '{we: 1'b1, addr: parent_idx, wdata: ST_FREE};
        idx_nxt   = parent_idx;
        lvl_nxt   = lvl_r - LVL_W'(1);
        state_nxt = (lvl_r == LVL_W'(1)) ? S_DONE : S_F_MRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: status_r, granted_offset: goff_r,
                            granted_size: gsize_r, allocated_total: total_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    offs_r     <= offs_nxt;
    idx_r      <= idx_nxt;
    lvl_r      <= lvl_nxt;
    tgt_r      <= tgt_nxt;
    p_r        <= p_nxt;
    status_r   <= status_nxt;
    goff_r     <= goff_nxt;
    gsize_r    <= gsize_nxt;
    out_data_r <= out_data_nxt;
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction taken while busy");

  a_err_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != RES_OK) |->
      (out_data.granted_size == '0 && out_data.granted_offset == '0))
    else $error("error result carries a block");

  a_ok_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == RES_OK) |-> $onehot(out_data.granted_size))
    else $error("granted size not a power of two");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !node_req.we)
    else $error("node write outside a transaction");

endmodule
